>>> rtl/n6502_pkg.sv
`default_nettype none

package n6502_pkg;

  localparam int CMD_W = 5;

  localparam logic [CMD_W-1:0] CMD_ORA = 5'd0;
  localparam logic [CMD_W-1:0] CMD_AND = 5'd1;
  localparam logic [CMD_W-1:0] CMD_EOR = 5'd2;
  localparam logic [CMD_W-1:0] CMD_ADC = 5'd3;
  localparam logic [CMD_W-1:0] CMD_SBC = 5'd4;
  localparam logic [CMD_W-1:0] CMD_CMP = 5'd5;
  localparam logic [CMD_W-1:0] CMD_BIT = 5'd6;
  localparam logic [CMD_W-1:0] CMD_ASL = 5'd7;
  localparam logic [CMD_W-1:0] CMD_LSR = 5'd8;
  localparam logic [CMD_W-1:0] CMD_ROL = 5'd9;
  localparam logic [CMD_W-1:0] CMD_ROR = 5'd10;
  localparam logic [CMD_W-1:0] CMD_INC = 5'd11;
  localparam logic [CMD_W-1:0] CMD_DEC = 5'd12;
  localparam logic [CMD_W-1:0] CMD_ANC = 5'd13;
  localparam logic [CMD_W-1:0] CMD_ALR = 5'd14;
  localparam logic [CMD_W-1:0] CMD_ARR = 5'd15;
  localparam logic [CMD_W-1:0] CMD_SBX = 5'd16;
  localparam logic [CMD_W-1:0] CMD_SLO = 5'd17;
  localparam logic [CMD_W-1:0] CMD_RLA = 5'd18;
  localparam logic [CMD_W-1:0] CMD_SRE = 5'd19;
  localparam logic [CMD_W-1:0] CMD_RRA = 5'd20;
  localparam logic [CMD_W-1:0] CMD_DCP = 5'd21;
  localparam logic [CMD_W-1:0] CMD_ISC = 5'd22;

  // Decimal correction constants.
  localparam logic [3:0] BCD_NIB_ADJ   = 4'h6;
  localparam logic [3:0] BCD_NIB_LIMIT = 4'h9;
  localparam logic [7:0] BCD_HI_ADJ    = 8'h60;
  localparam logic [8:0] BCD_HI_LIMIT  = 9'h09f;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // After decode: mem is the modified memory byte (or the operand untouched),
  // c is the carry seen by the rest of the pipe, t is A AND M (A AND X for SBX).
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       a;
    logic [7:0]       x;
    logic [7:0]       mem;
    logic [7:0]       t;
    logic             c;
    logic             d;
    logic             v;
  } s1_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       a;
    logic [7:0]       x;
    logic [7:0]       mem;
    logic             c;
    logic             d;
    logic             v;
    logic [8:0]       sum;
    logic [4:0]       dlo;
    logic [7:0]       lg;
    flags_t           arr;
  } s2_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       a;
    logic [7:0]       x;
    logic [7:0]       mem;
    logic             c;
    logic             d;
    logic             v;
    logic [8:0]       sum;
    logic [7:0]       lg;
    flags_t           arr;
    logic [7:0]       dec_acc;
    logic             dec_n;
    logic             dec_v;
    logic             dec_c;
  } s3_t;

endpackage

`default_nettype wire

>>> rtl/n6502_decode.sv
`default_nettype none

module n6502_decode (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [n6502_pkg::CMD_W-1:0] command,
  input  wire logic [7:0]                  acc,
  input  wire logic [7:0]                  index_x,
  input  wire logic [7:0]                  operand,
  input  wire logic                        carry_in,
  input  wire logic                        decimal_in,
  input  wire logic                        overflow_in,
  output logic                             out_valid,
  output n6502_pkg::s1_t                   out_data
);

  n6502_pkg::s1_t s1_next;

  always_comb begin
    s1_next.cmd = command;
    s1_next.a   = acc;
    s1_next.x   = index_x;
    s1_next.d   = decimal_in;
    s1_next.v   = overflow_in;
    s1_next.mem = operand;
    s1_next.c   = carry_in;
    s1_next.t   = (command == n6502_pkg::CMD_SBX) ? (acc & index_x) : (acc & operand);
    case (command)
      n6502_pkg::CMD_ASL, n6502_pkg::CMD_SLO: begin
        s1_next.mem = {operand[6:0], 1'b0};
        s1_next.c   = operand[7];
      end
      n6502_pkg::CMD_LSR, n6502_pkg::CMD_SRE: begin
        s1_next.mem = {1'b0, operand[7:1]};
        s1_next.c   = operand[0];
      end
      n6502_pkg::CMD_ROL, n6502_pkg::CMD_RLA: begin
        s1_next.mem = {operand[6:0], carry_in};
        s1_next.c   = operand[7];
      end
      n6502_pkg::CMD_ROR, n6502_pkg::CMD_RRA: begin
        s1_next.mem = {carry_in, operand[7:1]};
        s1_next.c   = operand[0];
      end
      n6502_pkg::CMD_INC, n6502_pkg::CMD_ISC: begin
        s1_next.mem = operand + 8'd1;
      end
      n6502_pkg::CMD_DEC, n6502_pkg::CMD_DCP: begin
        s1_next.mem = operand - 8'd1;
      end
      n6502_pkg::CMD_ANC: begin
        s1_next.c = acc[7] & operand[7];
      end
      n6502_pkg::CMD_ALR: begin
        s1_next.c = acc[0] & operand[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= s1_next;
  end

endmodule

`default_nettype wire

>>> rtl/n6502_arith.sv
`default_nettype none

module n6502_arith (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire n6502_pkg::s1_t in_data,
  output logic                out_valid,
  output n6502_pkg::s2_t      out_data
);

  n6502_pkg::s2_t s2_next;
  logic           is_add;
  logic           is_sub;
  logic           is_cmp;
  logic [7:0]     add_x;
  logic [7:0]     add_y;
  logic           add_c;
  logic [5:0]     lo_add;
  logic [5:0]     lo_add_adj;
  logic [4:0]     lo_sub;
  logic [7:0]     arr_r;
  logic [7:0]     arr_r1;
  logic           arr_lo_fix;
  logic           arr_hi_fix;

  always_comb begin
    is_add = in_data.cmd inside {n6502_pkg::CMD_ADC, n6502_pkg::CMD_RRA};
    is_sub = in_data.cmd inside {n6502_pkg::CMD_SBC, n6502_pkg::CMD_ISC};
    is_cmp = in_data.cmd inside {n6502_pkg::CMD_CMP, n6502_pkg::CMD_DCP, n6502_pkg::CMD_SBX};

    // One adder serves add, subtract and every compare.
    add_x = (in_data.cmd == n6502_pkg::CMD_SBX) ? in_data.t : in_data.a;
    add_y = is_add ? in_data.mem : ~in_data.mem;
    add_c = is_cmp ? 1'b1 : in_data.c;

    s2_next.cmd = in_data.cmd;
    s2_next.a   = in_data.a;
    s2_next.x   = in_data.x;
    s2_next.mem = in_data.mem;
    s2_next.c   = in_data.c;
    s2_next.d   = in_data.d;
    s2_next.v   = in_data.v;
    s2_next.sum = {1'b0, add_x} + {1'b0, add_y} + {8'b0, add_c};

    // Low nibble of the decimal add: corrected digit and its carry.
    lo_add     = {2'b0, in_data.a[3:0]} + {2'b0, in_data.mem[3:0]} + {5'b0, in_data.c};
    lo_add_adj = (lo_add > {2'b0, n6502_pkg::BCD_NIB_LIMIT}) ?
                 lo_add + {2'b0, n6502_pkg::BCD_NIB_ADJ} : lo_add;
    // Low nibble of the decimal subtract as a signed five-bit value; a borrow
    // subtracts six from the digit and keeps it negative.
    lo_sub = {1'b0, in_data.a[3:0]} - {1'b0, in_data.mem[3:0]} - {4'b0, ~in_data.c};
    if (is_sub) begin
      s2_next.dlo = lo_sub[4] ? {1'b1, lo_sub[3:0] - n6502_pkg::BCD_NIB_ADJ} : lo_sub;
    end else begin
      s2_next.dlo = {|lo_add_adj[5:4], lo_add_adj[3:0]};
    end

    arr_r      = {in_data.c, in_data.t[7:1]};
    arr_lo_fix = ({1'b0, in_data.t[3:0]} + {4'b0, in_data.t[0]}) > 5'd5;
    arr_hi_fix = ({1'b0, in_data.t[7:4]} + {4'b0, in_data.t[4]}) > 5'd5;
    arr_r1     = arr_lo_fix ? {arr_r[7:4], arr_r[3:0] + n6502_pkg::BCD_NIB_ADJ} : arr_r;
    if (in_data.d) begin
      s2_next.arr.n = in_data.c;
      s2_next.arr.z = (arr_r == 8'd0);
      s2_next.arr.v = in_data.t[6] ^ arr_r[6];
      s2_next.arr.c = arr_hi_fix;
    end else begin
      s2_next.arr.n = arr_r[7];
      s2_next.arr.z = (arr_r == 8'd0);
      s2_next.arr.v = in_data.t[7] ^ in_data.t[6];
      s2_next.arr.c = in_data.t[7];
    end

    case (in_data.cmd)
      n6502_pkg::CMD_ORA, n6502_pkg::CMD_SLO: s2_next.lg = in_data.a | in_data.mem;
      n6502_pkg::CMD_AND, n6502_pkg::CMD_RLA,
      n6502_pkg::CMD_BIT:                     s2_next.lg = in_data.a & in_data.mem;
      n6502_pkg::CMD_EOR, n6502_pkg::CMD_SRE: s2_next.lg = in_data.a ^ in_data.mem;
      n6502_pkg::CMD_ANC:                     s2_next.lg = in_data.t;
      n6502_pkg::CMD_ALR:                     s2_next.lg = {1'b0, in_data.t[7:1]};
      n6502_pkg::CMD_ARR: begin
        if (in_data.d && arr_hi_fix) begin
          s2_next.lg = arr_r1 + n6502_pkg::BCD_HI_ADJ;
        end else if (in_data.d) begin
          s2_next.lg = arr_r1;
        end else begin
          s2_next.lg = arr_r;
        end
      end
      default:                                s2_next.lg = in_data.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= s2_next;
  end

endmodule

`default_nettype wire

>>> rtl/n6502_bcd.sv
`default_nettype none

module n6502_bcd (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire n6502_pkg::s2_t in_data,
  output logic                out_valid,
  output n6502_pkg::s3_t      out_data
);

  n6502_pkg::s3_t s3_next;
  logic [4:0]     hi_add;
  logic [8:0]     r_add;
  logic [9:0]     r_add_adj;
  logic [9:0]     hi_sub;
  logic [9:0]     hi_sub_adj;

  always_comb begin
    s3_next.cmd = in_data.cmd;
    s3_next.a   = in_data.a;
    s3_next.x   = in_data.x;
    s3_next.mem = in_data.mem;
    s3_next.c   = in_data.c;
    s3_next.d   = in_data.d;
    s3_next.v   = in_data.v;
    s3_next.sum = in_data.sum;
    s3_next.lg  = in_data.lg;
    s3_next.arr = in_data.arr;

    // Decimal add: N and V are taken before the high digit is corrected.
    hi_add    = {1'b0, in_data.a[7:4]} + {1'b0, in_data.mem[7:4]} + {4'b0, in_data.dlo[4]};
    r_add     = {hi_add, in_data.dlo[3:0]};
    r_add_adj = (r_add > n6502_pkg::BCD_HI_LIMIT) ?
                {1'b0, r_add} + {2'b0, n6502_pkg::BCD_HI_ADJ} : {1'b0, r_add};

    // Decimal subtract: signed high part, corrected by 0x60 when negative.
    hi_sub     = {2'b0, in_data.a[7:4], 4'b0} - {2'b0, in_data.mem[7:4], 4'b0} +
                 {{5{in_data.dlo[4]}}, in_data.dlo};
    hi_sub_adj = hi_sub[9] ? hi_sub - {2'b0, n6502_pkg::BCD_HI_ADJ} : hi_sub;

    s3_next.dec_n = r_add[7];
    s3_next.dec_v = ~(in_data.a[7] ^ in_data.mem[7]) & (in_data.a[7] ^ r_add[7]);
    s3_next.dec_c = |r_add_adj[9:8];
    if (in_data.cmd inside {n6502_pkg::CMD_SBC, n6502_pkg::CMD_ISC}) begin
      s3_next.dec_acc = hi_sub_adj[7:0];
    end else begin
      s3_next.dec_acc = r_add_adj[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= s3_next;
  end

endmodule

`default_nettype wire

>>> rtl/n6502_result.sv
`default_nettype none

module n6502_result (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire n6502_pkg::s3_t in_data,
  output logic                done,
  output logic [7:0]          mem_result,
  output logic [7:0]          acc_out,
  output logic [7:0]          x_out,
  output logic                flag_n,
  output logic                flag_z,
  output logic                flag_c,
  output logic                flag_v
);

  logic [7:0]        acc_next;
  logic [7:0]        x_next;
  n6502_pkg::flags_t flags_next;
  logic              sum_zero;
  logic              lg_zero;
  logic              add_v;
  logic              sub_v;

  always_comb begin
    sum_zero = (in_data.sum[7:0] == 8'd0);
    lg_zero  = (in_data.lg == 8'd0);
    add_v    = ~(in_data.a[7] ^ in_data.mem[7]) & (in_data.a[7] ^ in_data.sum[7]);
    sub_v    = (in_data.a[7] ^ in_data.mem[7]) & (in_data.a[7] ^ in_data.sum[7]);

    acc_next     = in_data.a;
    x_next       = in_data.x;
    flags_next.n = 1'b0;
    flags_next.z = 1'b0;
    flags_next.c = in_data.c;
    flags_next.v = in_data.v;

    case (in_data.cmd)
      n6502_pkg::CMD_ORA, n6502_pkg::CMD_AND, n6502_pkg::CMD_EOR, n6502_pkg::CMD_ANC,
      n6502_pkg::CMD_ALR, n6502_pkg::CMD_SLO, n6502_pkg::CMD_RLA, n6502_pkg::CMD_SRE: begin
        acc_next     = in_data.lg;
        flags_next.n = in_data.lg[7];
        flags_next.z = lg_zero;
      end
      n6502_pkg::CMD_ADC, n6502_pkg::CMD_RRA: begin
        flags_next.z = sum_zero;
        if (in_data.d) begin
          acc_next     = in_data.dec_acc;
          flags_next.n = in_data.dec_n;
          flags_next.c = in_data.dec_c;
          flags_next.v = in_data.dec_v;
        end else begin
          acc_next     = in_data.sum[7:0];
          flags_next.n = in_data.sum[7];
          flags_next.c = in_data.sum[8];
          flags_next.v = add_v;
        end
      end
      n6502_pkg::CMD_SBC, n6502_pkg::CMD_ISC: begin
        acc_next     = in_data.d ? in_data.dec_acc : in_data.sum[7:0];
        flags_next.n = in_data.sum[7];
        flags_next.z = sum_zero;
        flags_next.c = in_data.sum[8];
        flags_next.v = sub_v;
      end
      n6502_pkg::CMD_CMP, n6502_pkg::CMD_DCP: begin
        flags_next.n = in_data.sum[7];
        flags_next.z = sum_zero;
        flags_next.c = in_data.sum[8];
      end
      n6502_pkg::CMD_SBX: begin
        x_next       = in_data.sum[7:0];
        flags_next.n = in_data.sum[7];
        flags_next.z = sum_zero;
        flags_next.c = in_data.sum[8];
      end
      n6502_pkg::CMD_BIT: begin
        flags_next.n = in_data.mem[7];
        flags_next.z = lg_zero;
        flags_next.v = in_data.mem[6];
      end
      n6502_pkg::CMD_ASL, n6502_pkg::CMD_LSR, n6502_pkg::CMD_ROL, n6502_pkg::CMD_ROR,
      n6502_pkg::CMD_INC, n6502_pkg::CMD_DEC: begin
        flags_next.n = in_data.mem[7];
        flags_next.z = (in_data.mem == 8'd0);
      end
      n6502_pkg::CMD_ARR: begin
        acc_next   = in_data.lg;
        flags_next = in_data.arr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mem_result <= in_data.mem;
    acc_out    <= acc_next;
    x_out      <= x_next;
    flag_n     <= flags_next.n;
    flag_z     <= flags_next.z;
    flag_c     <= flags_next.c;
    flag_v     <= flags_next.v;
  end

endmodule

`default_nettype wire

>>> rtl/nmos_6502_alu.sv
// Arithmetic-logic unit of an NMOS 6502-family CPU, as a four-stage pipeline.
// Input channel: an operation is taken at a rising edge where start is high
// and busy is low. busy is always low, so a new operation may be issued in
// every cycle; throughput is one operation per clock.
// Output channel: done is high for exactly one cycle while mem_result,
// acc_out, x_out and the four flags hold the result; the receiver must take
// it in that cycle, as it cannot hold the pipeline off.
// An operation taken at an edge passes through decode and memory shift or
// step, main adder and low decimal digit, high decimal digit, and flag and
// result selection, one register stage each, and then shows on the outputs
// with done.
// Results come out in issue order, one per operation, with no gaps between
// back-to-back operations.
// Reset (rst, synchronous) clears the stage valid bits, so no stale result
// is ever marked by done; operations in flight at reset are dropped.
`default_nettype none

module nmos_6502_alu (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [n6502_pkg::CMD_W-1:0] command,
  input  wire logic [7:0]                  acc,
  input  wire logic [7:0]                  index_x,
  input  wire logic [7:0]                  operand,
  input  wire logic                        carry_in,
  input  wire logic                        decimal_in,
  input  wire logic                        overflow_in,
  output logic                             done,
  output logic [7:0]                       mem_result,
  output logic [7:0]                       acc_out,
  output logic [7:0]                       x_out,
  output logic                             flag_n,
  output logic                             flag_z,
  output logic                             flag_c,
  output logic                             flag_v
);

  logic           s1_valid;
  n6502_pkg::s1_t s1;
  logic           s2_valid;
  n6502_pkg::s2_t s2;
  logic           s3_valid;
  n6502_pkg::s3_t s3;

  assign busy = 1'b0;

  n6502_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .command     (command),
    .acc         (acc),
    .index_x     (index_x),
    .operand     (operand),
    .carry_in    (carry_in),
    .decimal_in  (decimal_in),
    .overflow_in (overflow_in),
    .out_valid   (s1_valid),
    .out_data    (s1)
  );

  n6502_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1),
    .out_valid (s2_valid),
    .out_data  (s2)
  );

  n6502_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_data   (s2),
    .out_valid (s3_valid),
    .out_data  (s3)
  );

  n6502_result u_result (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s3_valid),
    .in_data    (s3),
    .done       (done),
    .mem_result (mem_result),
    .acc_out    (acc_out),
    .x_out      (x_out),
    .flag_n     (flag_n),
    .flag_z     (flag_z),
    .flag_c     (flag_c),
    .flag_v     (flag_v)
  );

  // Every accepted beat comes out as a result marked by done.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted beat did not produce a result after four cycles");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching accepted beat");

  // Operations that do not write memory return the operand unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (done && ($past(command, 4) == n6502_pkg::CMD_ORA ||
              $past(command, 4) == n6502_pkg::CMD_AND ||
              $past(command, 4) == n6502_pkg::CMD_EOR ||
              $past(command, 4) == n6502_pkg::CMD_ADC ||
              $past(command, 4) == n6502_pkg::CMD_SBC ||
              $past(command, 4) == n6502_pkg::CMD_CMP ||
              $past(command, 4) == n6502_pkg::CMD_BIT ||
              $past(command, 4) == n6502_pkg::CMD_SBX))
    |-> (mem_result == $past(operand, 4)))
    else $error("memory byte altered by an operation that does not write it");

  // Only SBX writes X.
  assert property (@(posedge clk) disable iff (rst)
    (done && ($past(command, 4) != n6502_pkg::CMD_SBX)) |-> (x_out == $past(index_x, 4)))
    else $error("X changed by an operation other than SBX");

  // Logic, BIT and increment or decrement leave the carry alone.
  assert property (@(posedge clk) disable iff (rst)
    (done && ($past(command, 4) == n6502_pkg::CMD_ORA ||
              $past(command, 4) == n6502_pkg::CMD_AND ||
              $past(command, 4) == n6502_pkg::CMD_EOR ||
              $past(command, 4) == n6502_pkg::CMD_BIT ||
              $past(command, 4) == n6502_pkg::CMD_INC ||
              $past(command, 4) == n6502_pkg::CMD_DEC))
    |-> (flag_c == $past(carry_in, 4)))
    else $error("carry changed by an operation that must preserve it");

endmodule

`default_nettype wire
